FILE: src/rph_pkg.sv
package rph_pkg;

  // fixed field widths
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int OPCODE_W    = 2;
  localparam int PIX_W       = 8;
  localparam int OUT_COUNT_W = 24;
  localparam int MAX_COUNT_W = 32;

  // parameter defaults
  localparam int DEF_BIN_COUNT       = 256;
  localparam int DEF_MAX_IMAGE_WIDTH = 4096;
  localparam int DEF_COUNT_WIDTH     = 24;

  // entries in the front-to-back queue
  localparam int QUEUE_DEPTH = 4;

  // input opcodes
  localparam logic [OPCODE_W-1:0] OP_PIXEL = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd4;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 13'd4096;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PIX_W-1:0]    pixel_value;
    logic [PIX_W-1:0]    read_bin;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]       bin_number;
    logic [OUT_COUNT_W-1:0] bin_count;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] region_left;
    logic [CFG_W-1:0] region_top;
    logic [CFG_W-1:0] region_width;
    logic [CFG_W-1:0] region_height;
  } cfg_t;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_INCR  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [PIX_W-1:0] bin;
    logic             oob;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: src/rph_front.sv
module rph_front import rph_pkg::*; #(
  parameter int BIN_COUNT       = DEF_BIN_COUNT,
  parameter int MAX_IMAGE_WIDTH = DEF_MAX_IMAGE_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  output logic     push,
  output qent_t    push_data
);

  localparam int POS_W = $clog2(MAX_IMAGE_WIDTH);
  localparam int CW    = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;

  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  logic [CW-1:0] img_w, row_len, col_ext, row_ext;
  logic          col_in, row_in, col_last, row_last;
  logic          pix_clamp, read_oob;

  // effective line length and rectangle test
  always_comb begin
    img_w   = CW'(cfg.image_width);
    row_len = (img_w == '0 || img_w > CW'(MAX_IMAGE_WIDTH)) ? CW'(MAX_IMAGE_WIDTH) : img_w;
    col_ext = CW'(col_r);
    row_ext = CW'(row_r);
    col_in  = (col_ext >= CW'(cfg.region_left)) &&
              ((col_ext - CW'(cfg.region_left)) < CW'(cfg.region_width));
    row_in  = (row_ext >= CW'(cfg.region_top)) &&
              ((row_ext - CW'(cfg.region_top)) < CW'(cfg.region_height));
    col_last = (col_ext + CW'(1)) >= row_len;
    row_last = row_r == POS_W'(MAX_IMAGE_WIDTH - 1);
    pix_clamp = {1'b0, in_item.pixel_value} >= (PIX_W+1)'(BIN_COUNT);
    read_oob  = {1'b0, in_item.read_bin} >= (PIX_W+1)'(BIN_COUNT);
  end

  // classify the item and advance the raster position
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    push          = 1'b0;
    push_data.cmd = CMD_INCR;
    push_data.bin = in_item.pixel_value;
    push_data.oob = 1'b0;
    if (in_fire) begin
      unique case (in_item.opcode)
        OP_PIXEL: begin
          push          = col_in && row_in;
          push_data.bin = pix_clamp ? PIX_W'(BIN_COUNT - 1) : in_item.pixel_value;
          if (col_last) begin
            col_nxt = '0;
            row_nxt = row_last ? '0 : row_r + POS_W'(1);
          end else begin
            col_nxt = col_r + POS_W'(1);
          end
        end
        OP_READ: begin
          push          = 1'b1;
          push_data.cmd = CMD_READ;
          push_data.bin = in_item.read_bin;
          push_data.oob = read_oob;
        end
        OP_CLEAR: begin
          push          = 1'b1;
          push_data.cmd = CMD_CLEAR;
          col_nxt       = '0;
          row_nxt       = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: src/rph_queue.sv
module rph_queue import rph_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  qent_t     push_data,
  input  logic      pop,
  output qent_t     pop_data,
  output q_status_t status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t            ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = ent_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // a push into a full queue would lose an item
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push)
    else $error("push into full queue");

  // fill count rises on a push without a pop
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count mismatch");

endmodule

FILE: src/rph_back.sv
module rph_back import rph_pkg::*; #(
  parameter int BIN_COUNT   = DEF_BIN_COUNT,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_status,
  input  qent_t     pop_data,
  output logic      pop,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int BIN_W = $clog2(BIN_COUNT);

  logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [BIN_COUNT-1:0]   vld_r;

  logic                   s1_valid_r;
  qent_t                  s1_ent_r;
  logic                   lw_valid_r;
  logic [BIN_W-1:0]       lw_idx_r;
  logic [COUNT_WIDTH-1:0] lw_data_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [BIN_W-1:0]       pop_idx, s1_idx;
  logic [COUNT_WIDTH-1:0] cur, inc;
  logic                   wr_en;
  logic [MAX_COUNT_W-1:0] cur_wide;

  assign pop     = !q_status.empty;
  assign pop_idx = pop_data.bin[BIN_W-1:0];
  assign s1_idx  = s1_ent_r.bin[BIN_W-1:0];

  // current count: last write, else memory gated by valid bit
  always_comb begin
    if (lw_valid_r && lw_idx_r == s1_idx) begin
      cur = lw_data_r;
    end else if (vld_r[s1_idx]) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end
    inc      = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);
    wr_en    = s1_valid_r && s1_ent_r.cmd == CMD_INCR;
    cur_wide = MAX_COUNT_W'(cur);
  end

  // bin memory, one read and one write port
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= mem[pop_idx];
    end
    if (wr_en) begin
      mem[s1_idx] <= inc;
    end
  end

  // execute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= pop;
      lw_valid_r  <= wr_en;
      out_valid_r <= s1_valid_r && s1_ent_r.cmd == CMD_READ;
      if (wr_en) begin
        vld_r[s1_idx] <= 1'b1;
      end
      if (s1_valid_r && s1_ent_r.cmd == CMD_CLEAR) begin
        vld_r <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ent_r <= pop_data;
    end
    lw_idx_r  <= s1_idx;
    lw_data_r <= inc;
    if (s1_valid_r && s1_ent_r.cmd == CMD_READ) begin
      out_item_r.bin_number <= s1_ent_r.bin;
      out_item_r.bin_count  <= s1_ent_r.oob ? '0 : cur_wide[OUT_COUNT_W-1:0];
    end
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

  // a clear leaves every bin empty
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ent_r.cmd == CMD_CLEAR) |=> vld_r == '0)
    else $error("bins not cleared");

  // every read yields exactly one result next cycle
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ent_r.cmd == CMD_READ) |=> out_strobe)
    else $error("read result missing");

  // no result without a read
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(s1_valid_r && s1_ent_r.cmd == CMD_READ))
    else $error("spurious result");

endmodule

FILE: src/roi_pixel_histogram.sv
// Region-of-interest grey-level histogram. Takes one command per clock
// (start while busy is low): a pixel in raster order, a bin read or a
// clear. Pixels inside the configured rectangle bump a saturating bin in
// a bin memory with one read and one write port; the back end reads,
// increments and writes one bin per clock with a last-write bypass and
// drains one queue entry per clock, so the four-entry command queue never
// holds more than one entry and busy stays low under a sustained stream of
// one item per cycle. A clear resets all bins at once through per-bin
// valid bits and needs no sweep. A read result appears on out_item with
// out_strobe for one cycle, after the read has passed the queue, the
// execute stage and the output register; out_strobe cannot be stalled and
// must be captured when it is high.
// Configuration writes are always ready and must only be made while idle.
module roi_pixel_histogram import rph_pkg::*; #(
  parameter int BIN_COUNT       = DEF_BIN_COUNT,
  parameter int MAX_IMAGE_WIDTH = DEF_MAX_IMAGE_WIDTH,
  parameter int COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_strobe,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t      cfg_r;
  logic      in_fire;
  logic      push, pop;
  qent_t     push_data, pop_data;
  q_status_t q_status;

  assign cfg_ready = 1'b1;
  assign busy      = q_status.full;
  assign in_fire   = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= IMAGE_WIDTH_RESET;
      cfg_r.region_left   <= '0;
      cfg_r.region_top    <= '0;
      cfg_r.region_width  <= '0;
      cfg_r.region_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   cfg_r.image_width   <= cfg_data;
        REG_REGION_LEFT:   cfg_r.region_left   <= cfg_data;
        REG_REGION_TOP:    cfg_r.region_top    <= cfg_data;
        REG_REGION_WIDTH:  cfg_r.region_width  <= cfg_data;
        REG_REGION_HEIGHT: cfg_r.region_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // position tracking and classification
  rph_front #(
    .BIN_COUNT       (BIN_COUNT),
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .push      (push),
    .push_data (push_data)
  );

  // command queue
  rph_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // bin memory and read-modify-write
  rph_back #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
